// File: rtl/seed_pkg.sv
// SEED cipher package: S-box tables, G function, round constants.
// No dependencies; imported by every module of the SEED core.
package seed_pkg;

   localparam int RoundCount = 16;
   localparam int WordWidth  = 32;
   localparam logic [31:0] Golden = 32'h9E3779B9;

   localparam logic [1:0] CSR_KEY_WORD_0 = 2'd0;
   localparam logic [1:0] CSR_KEY_WORD_1 = 2'd1;
   localparam logic [1:0] CSR_KEY_WORD_2 = 2'd2;
   localparam logic [1:0] CSR_KEY_WORD_3 = 2'd3;

   typedef logic [31:0] word_type;

   localparam logic [7:0] SBOX1 [256] = '{
      8'hA9,8'h85,8'hD6,8'hD3,8'h54,8'h1D,8'hAC,8'h25,8'h5D,8'h43,8'h18,8'h1E,8'h51,8'hFC,8'hCA,8'h63,
      8'h28,8'h44,8'h20,8'h9D,8'hE0,8'hE2,8'hC8,8'h17,8'hA5,8'h8F,8'h03,8'h7B,8'hBB,8'h13,8'hD2,8'hEE,
      8'h70,8'h8C,8'h3F,8'hA8,8'h32,8'hDD,8'hF6,8'h74,8'hEC,8'h95,8'h0B,8'h57,8'h5C,8'h5B,8'hBD,8'h01,
      8'h24,8'h1C,8'h73,8'h98,8'h10,8'hCC,8'hF2,8'hD9,8'h2C,8'hE7,8'h72,8'h83,8'h9B,8'hD1,8'h86,8'hC9,
      8'h60,8'h50,8'hA3,8'hEB,8'h0D,8'hB6,8'h9E,8'h4F,8'hB7,8'h5A,8'hC6,8'h78,8'hA6,8'h12,8'hAF,8'hD5,
      8'h61,8'hC3,8'hB4,8'h41,8'h52,8'h7D,8'h8D,8'h08,8'h1F,8'h99,8'h00,8'h19,8'h04,8'h53,8'hF7,8'hE1,
      8'hFD,8'h76,8'h2F,8'h27,8'hB0,8'h8B,8'h0E,8'hAB,8'hA2,8'h6E,8'h93,8'h4D,8'h69,8'h7C,8'h09,8'h0A,
      8'hBF,8'hEF,8'hF3,8'hC5,8'h87,8'h14,8'hFE,8'h64,8'hDE,8'h2E,8'h4B,8'h1A,8'h06,8'h21,8'h6B,8'h66,
      8'h02,8'hF5,8'h92,8'h8A,8'h0C,8'hB3,8'h7E,8'hD0,8'h7A,8'h47,8'h96,8'hE5,8'h26,8'h80,8'hAD,8'hDF,
      8'hA1,8'h30,8'h37,8'hAE,8'h36,8'h15,8'h22,8'h38,8'hF4,8'hA7,8'h45,8'h4C,8'h81,8'hE9,8'h84,8'h97,
      8'h35,8'hCB,8'hCE,8'h3C,8'h71,8'h11,8'hC7,8'h89,8'h75,8'hFB,8'hDA,8'hF8,8'h94,8'h59,8'h82,8'hC4,
      8'hFF,8'h49,8'h39,8'h67,8'hC0,8'hCF,8'hD7,8'hB8,8'h0F,8'h8E,8'h42,8'h23,8'h91,8'h6C,8'hDB,8'hA4,
      8'h34,8'hF1,8'h48,8'hC2,8'h6F,8'h3D,8'h2D,8'h40,8'hBE,8'h3E,8'hBC,8'hC1,8'hAA,8'hBA,8'h4E,8'h55,
      8'h3B,8'hDC,8'h68,8'h7F,8'h9C,8'hD8,8'h4A,8'h56,8'h77,8'hA0,8'hED,8'h46,8'hB5,8'h2B,8'h65,8'hFA,
      8'hE3,8'hB9,8'hB1,8'h9F,8'h5E,8'hF9,8'hE6,8'hB2,8'h31,8'hEA,8'h6D,8'h5F,8'hE4,8'hF0,8'hCD,8'h88,
      8'h16,8'h3A,8'h58,8'hD4,8'h62,8'h29,8'h07,8'h33,8'hE8,8'h1B,8'h05,8'h79,8'h90,8'h6A,8'h2A,8'h9A
   };

   localparam logic [7:0] SBOX2 [256] = '{
      8'h38,8'hE8,8'h2D,8'hA6,8'hCF,8'hDE,8'hB3,8'hB8,8'hAF,8'h60,8'h55,8'hC7,8'h44,8'h6F,8'h6B,8'h5B,
      8'hC3,8'h62,8'h33,8'hB5,8'h29,8'hA0,8'hE2,8'hA7,8'hD3,8'h91,8'h11,8'h06,8'h1C,8'hBC,8'h36,8'h4B,
      8'hEF,8'h88,8'h6C,8'hA8,8'h17,8'hC4,8'h16,8'hF4,8'hC2,8'h45,8'hE1,8'hD6,8'h3F,8'h3D,8'h8E,8'h98,
      8'h28,8'h4E,8'hF6,8'h3E,8'hA5,8'hF9,8'h0D,8'hDF,8'hD8,8'h2B,8'h66,8'h7A,8'h27,8'h2F,8'hF1,8'h72,
      8'h42,8'hD4,8'h41,8'hC0,8'h73,8'h67,8'hAC,8'h8B,8'hF7,8'hAD,8'h80,8'h1F,8'hCA,8'h2C,8'hAA,8'h34,
      8'hD2,8'h0B,8'hEE,8'hE9,8'h5D,8'h94,8'h18,8'hF8,8'h57,8'hAE,8'h08,8'hC5,8'h13,8'hCD,8'h86,8'hB9,
      8'hFF,8'h7D,8'hC1,8'h31,8'hF5,8'h8A,8'h6A,8'hB1,8'hD1,8'h20,8'hD7,8'h02,8'h22,8'h04,8'h68,8'h71,
      8'h07,8'hDB,8'h9D,8'h99,8'h61,8'hBE,8'hE6,8'h59,8'hDD,8'h51,8'h90,8'hDC,8'h9A,8'hA3,8'hAB,8'hD0,
      8'h81,8'h0F,8'h47,8'h1A,8'hE3,8'hEC,8'h8D,8'hBF,8'h96,8'h7B,8'h5C,8'hA2,8'hA1,8'h63,8'h23,8'h4D,
      8'hC8,8'h9E,8'h9C,8'h3A,8'h0C,8'h2E,8'hBA,8'h6E,8'h9F,8'h5A,8'hF2,8'h92,8'hF3,8'h49,8'h78,8'hCC,
      8'h15,8'hFB,8'h70,8'h75,8'h7F,8'h35,8'h10,8'h03,8'h64,8'h6D,8'hC6,8'h74,8'hD5,8'hB4,8'hEA,8'h09,
      8'h76,8'h19,8'hFE,8'h40,8'h12,8'hE0,8'hBD,8'h05,8'hFA,8'h01,8'hF0,8'h2A,8'h5E,8'hA9,8'h56,8'h43,
      8'h85,8'h14,8'h89,8'h9B,8'hB0,8'hE5,8'h48,8'h79,8'h97,8'hFC,8'h1E,8'h82,8'h21,8'h8C,8'h1B,8'h5F,
      8'h77,8'h54,8'hB2,8'h1D,8'h25,8'h4F,8'h00,8'h46,8'hED,8'h58,8'h52,8'hEB,8'h7E,8'hDA,8'hC9,8'hFD,
      8'h30,8'h95,8'h65,8'h3C,8'hB6,8'hE4,8'hBB,8'h7C,8'h0E,8'h50,8'h39,8'h26,8'h32,8'h84,8'h69,8'h93,
      8'h37,8'hE7,8'h24,8'hA4,8'hCB,8'h53,8'h0A,8'h87,8'hD9,8'h4C,8'h83,8'h8F,8'hCE,8'h3B,8'h4A,8'hB7
   };

   localparam logic [7:0] BYTE_MASK [4] = '{8'hFC, 8'hF3, 8'hCF, 8'h3F};

   // G function: S-box on each byte, then masked byte mix.
   function automatic word_type g_func(input word_type x);
      logic [7:0] y [4];
      word_type   z;
      z = '0;
      for (int j = 0; j < 4; j++) begin
         y[j] = (j % 2 == 1) ? SBOX2[x[8*j +: 8]] : SBOX1[x[8*j +: 8]];
      end
      for (int k = 0; k < 4; k++) begin
         for (int j = 0; j < 4; j++) begin
            z[8*k +: 8] = z[8*k +: 8] ^ (y[j] & BYTE_MASK[(k + j) % 4]);
         end
      end
      return z;
   endfunction

   function automatic word_type rotl32(input word_type v, input int s);
      return (v << s) | (v >> ((32 - s) % 32));
   endfunction

endpackage

// File: rtl/seed_key_sched.sv
// SEED key schedule: registered round keys from the configured key.
// Depends on seed_pkg. Recomputed whenever the key registers change.
module seed_key_sched #(
   parameter int ROUND_COUNT = seed_pkg::RoundCount
) (
   input  logic                clock,
   input  seed_pkg::word_type  key_word [4],
   output seed_pkg::word_type  rk_even [ROUND_COUNT],
   output seed_pkg::word_type  rk_odd  [ROUND_COUNT]
);
   import seed_pkg::*;

   word_type ka [ROUND_COUNT];
   word_type kb [ROUND_COUNT];
   word_type rk_even_ff [ROUND_COUNT];
   word_type rk_odd_ff  [ROUND_COUNT];

   // Key words per round; rotations are fixed wiring, no logic depth.
   always_comb begin
      logic [63:0] k01, k23;
      k01 = {key_word[0], key_word[1]};
      k23 = {key_word[2], key_word[3]};
      for (int i = 0; i < ROUND_COUNT; i++) begin
         ka[i] = k01[63:32] + k23[63:32] - rotl32(Golden, i % 32);
         kb[i] = k01[31:0] - k23[31:0] + rotl32(Golden, i % 32);
         if (i % 2 == 0) begin
            k01 = {k01[7:0], k01[63:8]};
         end else begin
            k23 = {k23[55:0], k23[63:56]};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ROUND_COUNT; i++) begin
         rk_even_ff[i] <= g_func(ka[i]);
         rk_odd_ff[i]  <= g_func(kb[i]);
      end
   end

   assign rk_even = rk_even_ff;
   assign rk_odd  = rk_odd_ff;

endmodule

// File: rtl/seed_round.sv
// SEED round stage: one Feistel round split over three register stages.
// Depends on seed_pkg. Instantiated once per round by the top level.
module seed_round (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_func,
   input  seed_pkg::word_type in_l0,
   input  seed_pkg::word_type in_l1,
   input  seed_pkg::word_type in_r0,
   input  seed_pkg::word_type in_r1,
   input  seed_pkg::word_type k0,
   input  seed_pkg::word_type k1,
   input  logic               last,
   output logic               out_valid,
   output logic               out_func,
   output seed_pkg::word_type out_l0,
   output seed_pkg::word_type out_l1,
   output seed_pkg::word_type out_r0,
   output seed_pkg::word_type out_r1
);
   import seed_pkg::*;

   typedef struct packed {
      logic     func;
      word_type l0, l1, r0, r1;
   } blk_type;

   logic     v_ff [3];
   blk_type  b_ff [3];
   word_type a_ff, t1a_ff, t1a2_ff, t0_ff, t1b_ff, t0_ff_q;
   blk_type  b_in;
   word_type a_in, t1_in, t1c;
   word_type c, d;

   assign b_in = '{in_func, in_l0, in_l1, in_r0, in_r1};
   assign a_in = in_r0 ^ k0;
   assign t1_in = g_func(a_in ^ in_r1 ^ k1);
   assign t1c = g_func(t1a2_ff + t0_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '{1'b0, 1'b0, 1'b0};
      end else begin
         v_ff[0] <= in_valid;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
      end
      // stage 1: first G; stage 2: second G; stage 3: third G
      b_ff[0] <= b_in;
      a_ff    <= a_in;
      t1a_ff  <= t1_in;
      b_ff[1] <= b_ff[0];
      t0_ff   <= g_func(t1a_ff + a_ff);
      t1a2_ff <= t1a_ff;
      b_ff[2] <= b_ff[1];
      t1b_ff  <= t1c;
   end

   // Final add and swap (no swap in the last round) on the output of the third stage.
   assign d = t1b_ff;
   assign c = t0_ff_q + t1b_ff;
   always_ff @(posedge clock) begin
      t0_ff_q <= t0_ff;
   end

   assign out_valid = v_ff[2];
   assign out_func  = b_ff[2].func;
   assign out_l0 = last ? (b_ff[2].l0 ^ c) : b_ff[2].r0;
   assign out_l1 = last ? (b_ff[2].l1 ^ d) : b_ff[2].r1;
   assign out_r0 = last ? b_ff[2].r0 : (b_ff[2].l0 ^ c);
   assign out_r1 = last ? b_ff[2].r1 : (b_ff[2].l1 ^ d);

endmodule

// File: rtl/seed_block_cipher_128.sv
// SEED block cipher core, 128-bit key: key registers, schedule and round pipeline.
// Depends on seed_pkg, seed_key_sched and seed_round.
//
//   channel  ports                          direction  accept
//   req      start/busy, req_func, words    in         start && !busy
//   rsp      rsp_valid, rsp_out_word_*      out        every rsp_valid cycle
//   csr      csr_valid/ready, index, data   in         csr_valid && csr_ready
//
// Pipeline: the register stages of each round in turn, plus one output register.
// A new block is taken every cycle; busy stays low, the receiver cannot stall.
// Reset clears the key registers and all stage valid bits.
// A key write goes to the key registers, and the round keys are registered from them.
module seed_block_cipher_128 #(
   parameter int ROUND_COUNT = seed_pkg::RoundCount
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_func,
   input  logic [31:0]         req_block_word_0,
   input  logic [31:0]         req_block_word_1,
   input  logic [31:0]         req_block_word_2,
   input  logic [31:0]         req_block_word_3,
   output logic                rsp_valid,
   output logic [31:0]         rsp_out_word_0,
   output logic [31:0]         rsp_out_word_1,
   output logic [31:0]         rsp_out_word_2,
   output logic [31:0]         rsp_out_word_3,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data
);
   import seed_pkg::*;

   word_type key_ff [4];
   word_type rk_even [ROUND_COUNT];
   word_type rk_odd  [ROUND_COUNT];

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '{32'd0, 32'd0, 32'd0, 32'd0};
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_WORD_0: key_ff[0] <= csr_data;
            CSR_KEY_WORD_1: key_ff[1] <= csr_data;
            CSR_KEY_WORD_2: key_ff[2] <= csr_data;
            CSR_KEY_WORD_3: key_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   seed_key_sched #(.ROUND_COUNT(ROUND_COUNT)) u_sched (
      .clock(clock), .key_word(key_ff), .rk_even(rk_even), .rk_odd(rk_odd)
   );

   logic     sv [ROUND_COUNT+1];
   logic     sf [ROUND_COUNT+1];
   word_type s0 [ROUND_COUNT+1];
   word_type s1 [ROUND_COUNT+1];
   word_type s2 [ROUND_COUNT+1];
   word_type s3 [ROUND_COUNT+1];

   assign sv[0] = start;
   assign sf[0] = req_func;
   assign s0[0] = req_block_word_0;
   assign s1[0] = req_block_word_1;
   assign s2[0] = req_block_word_2;
   assign s3[0] = req_block_word_3;

   for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
      word_type k0, k1;
      // Select ascending keys to encrypt, descending to decrypt.
      assign k0 = sf[i] ? rk_even[i] : rk_even[ROUND_COUNT-1-i];
      assign k1 = sf[i] ? rk_odd[i]  : rk_odd[ROUND_COUNT-1-i];
      seed_round u_round (
         .clock(clock), .reset(reset),
         .in_valid(sv[i]), .in_func(sf[i]),
         .in_l0(s0[i]), .in_l1(s1[i]), .in_r0(s2[i]), .in_r1(s3[i]),
         .k0(k0), .k1(k1), .last(i == ROUND_COUNT-1),
         .out_valid(sv[i+1]), .out_func(sf[i+1]),
         .out_l0(s0[i+1]), .out_l1(s1[i+1]), .out_r0(s2[i+1]), .out_r1(s3[i+1])
      );
   end

   logic     rsp_valid_ff;
   word_type o0_ff, o1_ff, o2_ff, o3_ff;

   // Register the last round's output; drop nothing.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sv[ROUND_COUNT];
      end
      o0_ff <= s0[ROUND_COUNT];
      o1_ff <= s1[ROUND_COUNT];
      o2_ff <= s2[ROUND_COUNT];
      o3_ff <= s3[ROUND_COUNT];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_word_0 = o0_ff;
   assign rsp_out_word_1 = o1_ff;
   assign rsp_out_word_2 = o2_ff;
   assign rsp_out_word_3 = o3_ff;

endmodule

// File: tb/sv/seed_block_cipher_128_checker.sv
// Checker for the SEED core: watches key writes, accepted blocks and results.
// Predicts each block from its own key copy; depends on seed_pkg tables and the round constant only.
`timescale 1ns / 100ps

module seed_block_cipher_128_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_func,
   input  logic [31:0] req_block_word_0,
   input  logic [31:0] req_block_word_1,
   input  logic [31:0] req_block_word_2,
   input  logic [31:0] req_block_word_3,
   input  logic        rsp_valid,
   input  logic [31:0] rsp_out_word_0,
   input  logic [31:0] rsp_out_word_1,
   input  logic [31:0] rsp_out_word_2,
   input  logic [31:0] rsp_out_word_3,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          error_count,
   output int          blocks_pending,
   output int          results_seen
);
   import seed_pkg::*;

   logic [31:0]  key_copy [4];
   logic [127:0] expected_blocks [$];

   function automatic logic [31:0] sbox_mix(input logic [31:0] x);
      logic [7:0]  y [4];
      logic [31:0] z;
      z = '0;
      for (int j = 0; j < 4; j++) begin
         y[j] = j[0] ? SBOX2[x[8*j +: 8]] : SBOX1[x[8*j +: 8]];
      end
      for (int k = 0; k < 4; k++) begin
         for (int j = 0; j < 4; j++) begin
            z[8*k +: 8] ^= y[j] & BYTE_MASK[(k + j) & 3];
         end
      end
      return z;
   endfunction

   function automatic logic [127:0] seed_transform(input logic encrypt,
                                                   input logic [127:0] blk);
      logic [31:0] rk [32];
      logic [31:0] k0, k1, k2, k3, t, kc, l0, l1, r0, r1, a, c, d, n0, n1;
      int p;
      k0 = key_copy[0]; k1 = key_copy[1]; k2 = key_copy[2]; k3 = key_copy[3];
      for (int i = 0; i < 16; i++) begin
         kc = (i == 0) ? Golden : ((Golden << i) | (Golden >> (32 - i)));
         rk[2*i]     = sbox_mix(k0 + k2 - kc);
         rk[2*i + 1] = sbox_mix(k1 - k3 + kc);
         if (i % 2 == 0) begin
            t  = k0;
            k0 = {k1[7:0], k0[31:8]};
            k1 = {t[7:0], k1[31:8]};
         end else begin
            t  = k2;
            k2 = {k2[23:0], k3[31:24]};
            k3 = {k3[23:0], t[31:24]};
         end
      end
      {l0, l1, r0, r1} = blk;
      for (int i = 0; i < 16; i++) begin
         p = encrypt ? i : 15 - i;
         a = r0 ^ rk[2*p];
         d = sbox_mix(a ^ r1 ^ rk[2*p + 1]);
         c = sbox_mix(d + a);
         d = sbox_mix(d + c);
         c = c + d;
         if (i < 15) begin
            n0 = l0 ^ c; n1 = l1 ^ d;
            l0 = r0; l1 = r1; r0 = n0; r1 = n1;
         end else begin
            l0 ^= c; l1 ^= d;
         end
      end
      return {l0, l1, r0, r1};
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] MISMATCH %s: got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      results_seen = 0;
   end

   assign blocks_pending = expected_blocks.size();

   always @(posedge clock) begin
      logic [127:0] want;
      if (reset) begin
         for (int i = 0; i < 4; i++) key_copy[i] = '0;
         expected_blocks.delete();
      end else begin
         if (rsp_valid) begin
            results_seen++;
            if (expected_blocks.size() == 0) begin
               report_mismatch("unexpected result word", rsp_out_word_0, 32'h0);
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_out_word_0 !== want[127:96])
                  report_mismatch("out_word_0", rsp_out_word_0, want[127:96]);
               if (rsp_out_word_1 !== want[95:64])
                  report_mismatch("out_word_1", rsp_out_word_1, want[95:64]);
               if (rsp_out_word_2 !== want[63:32])
                  report_mismatch("out_word_2", rsp_out_word_2, want[63:32]);
               if (rsp_out_word_3 !== want[31:0])
                  report_mismatch("out_word_3", rsp_out_word_3, want[31:0]);
            end
         end
         if (start && !busy)
            expected_blocks.push_back(seed_transform(req_func,
               {req_block_word_0, req_block_word_1, req_block_word_2, req_block_word_3}));
         if (csr_valid && csr_ready) key_copy[csr_index] = csr_data;
      end
   end

endmodule

// File: tb/sv/seed_block_cipher_128_test.sv
// Top of the SEED core testbench: clock, reset, key writes and block stimulus.
// Depends on seed_pkg, the core and seed_block_cipher_128_checker.
`timescale 1ns / 100ps

module seed_block_cipher_128_test;
   import seed_pkg::*;

   localparam int DrainCycles = 64;     // covers the whole pipeline
   localparam int WatchdogLimit = 4000;

   logic        clock, reset, start, busy, req_func;
   logic [31:0] req_block_word_0, req_block_word_1, req_block_word_2, req_block_word_3;
   logic        rsp_valid;
   logic [31:0] rsp_out_word_0, rsp_out_word_1, rsp_out_word_2, rsp_out_word_3;
   logic        csr_valid, csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;
   int          error_count, blocks_pending, results_seen;
   int          blocks_sent, key_settings, idle_cycles;

   seed_block_cipher_128 u_top (.*);
   seed_block_cipher_128_checker u_checker (.*);

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   // Bail out if nothing moves on any channel for too long.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog expired, %0d blocks still pending", blocks_pending);
         $display("seed_block_cipher_128_test: errors");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // Hold until every pending block has come back, then let the pipe drain.
   task automatic drain_pipe();
      @(negedge clock);
      while (blocks_pending != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_key(input logic [31:0] k [4]);
      logic ok;
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= i[1:0];
         csr_data  <= k[i];
         forever begin
            #1 ok = csr_ready;
            @(posedge clock);
            if (ok) break;
            @(negedge clock);
         end
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      // let the registered round keys settle
      repeat (3) @(negedge clock);
      key_settings++;
   endtask

   // Send one block; gap cycles with start low come first.
   task automatic send_block(input logic enc, input logic [127:0] blk, input int gap);
      logic ok;
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_func <= enc;
      {req_block_word_0, req_block_word_1, req_block_word_2, req_block_word_3} <= blk;
      forever begin
         #1 ok = !busy;
         @(posedge clock);
         if (ok) break;
         @(negedge clock);
      end
      blocks_sent++;
   endtask

   function automatic logic [127:0] random_block();
      return {$urandom(), $urandom(), $urandom(), $urandom()};
   endfunction

   initial begin
      logic [31:0] key [4];
      int          burst;
      start = 0; req_func = 0; csr_valid = 0; csr_index = 0; csr_data = 0;
      {req_block_word_0, req_block_word_1, req_block_word_2, req_block_word_3} = '0;
      blocks_sent = 0; key_settings = 0; idle_cycles = 0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset key, then all-ones key; extreme and patterned blocks.
      for (int pass = 0; pass < 2; pass++) begin
         if (pass == 1) begin
            key = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
            write_key(key);
         end
         for (int f = 0; f < 2; f++) begin
            send_block(f[0], '0, 0);
            send_block(f[0], '1, 0);
            send_block(f[0], {4{32'h55555555}}, 1);
            send_block(f[0], {4{32'hAAAAAAAA}}, 0);
            send_block(f[0], 128'h000102030405060708090A0B0C0D0E0F, 2);
         end
         @(negedge clock);
         start <= 1'b0;
         drain_pipe();
      end
      key = '{32'h00010203, 32'h04050607, 32'h08090A0B, 32'h0C0D0E0F};
      write_key(key);
      send_block(1'b1, '0, 0);
      send_block(1'b0, 128'h0123456789ABCDEFFEDCBA9876543210, 0);

      // Random: a new key per phase, bursts in every third phase and random gaps in the others.
      for (int phase = 0; phase < 10; phase++) begin
         @(negedge clock);
         start <= 1'b0;
         drain_pipe();
         for (int i = 0; i < 4; i++) key[i] = $urandom();
         if (phase == 8) key = '{32'h0, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF};
         write_key(key);
         burst = phase % 3 == 0;
         for (int n = 0; n < 200; n++) begin
            if (n == 100) begin
               // pause the sender until the pipe has emptied
               @(negedge clock);
               start <= 1'b0;
               @(negedge clock);
               while (blocks_pending != 0) @(negedge clock);
            end
            send_block($urandom_range(0, 1), random_block(),
                       burst ? 0 : $urandom_range(0, 6));
         end
      end
      @(negedge clock);
      start <= 1'b0;
      drain_pipe();

      $display("sent %0d blocks under %0d key settings, %0d results checked",
               blocks_sent, key_settings, results_seen);
      if (error_count == 0)
         $display("seed_block_cipher_128_test: clean");
      else
         $display("seed_block_cipher_128_test: errors");
      $finish;
   end

endmodule
